FILE: src/mpwd_pkg.sv
// Shared types and codes for the Manchester pulse-width decoder.
`timescale 1ns / 1ps
`default_nettype none
package mpwd_pkg;

	// Field widths
	localparam int WIDTH_W = 16;
	localparam int COUNT_W = 8;
	localparam int BYTE_W  = 8;
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_MIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRE_LONGS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PKT_BITS  = 3'd4;

	// Register reset values
	localparam logic [WIDTH_W-1:0] RST_SHORT_MIN = 16'd200;
	localparam logic [WIDTH_W-1:0] RST_LONG_MIN  = 16'd700;
	localparam logic [WIDTH_W-1:0] RST_MAX_WIDTH = 16'd1200;
	localparam logic [COUNT_W-1:0] RST_PRE_LONGS = 8'd31;
	localparam logic [COUNT_W-1:0] RST_PKT_BITS  = 8'd136;

	// Pulse classes
	localparam logic [1:0] CLS_RANGE = 2'd0;
	localparam logic [1:0] CLS_SHORT = 2'd1;
	localparam logic [1:0] CLS_LONG  = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_RANGE  = 2'd1;
	localparam logic [1:0] ST_BROKEN = 2'd2;
	localparam logic [1:0] ST_BYTE   = 2'd3;

	// Decoder phases
	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_T0   = 2'd1;
	localparam logic [1:0] PH_OK   = 2'd2;

	// Classified pulse passed from front to back
	typedef struct packed {
		logic [1:0]         cls;
		logic [WIDTH_W-1:0] width;
	} item_t;

	// Packet settings used by the back end
	typedef struct packed {
		logic [COUNT_W-1:0] pre_longs;
		logic [COUNT_W-1:0] pkt_bits;
	} pkt_cfg_t;

endpackage
`default_nettype wire

FILE: src/mpwd_front.sv
// Front end: configuration registers and pulse width classification.
`timescale 1ns / 1ps
`default_nettype none
module mpwd_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [mpwd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mpwd_pkg::WIDTH_W-1:0]  cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [mpwd_pkg::WIDTH_W-1:0]  pulse_width,
	input  wire logic                          q_full,
	output logic                               q_push,
	output mpwd_pkg::item_t                    q_item,
	output mpwd_pkg::pkt_cfg_t                 pkt_cfg
);

	logic [mpwd_pkg::WIDTH_W-1:0] short_min_q, long_min_q, max_width_q;
	logic [mpwd_pkg::COUNT_W-1:0] pre_longs_q, pkt_bits_q;
	logic                         in_window;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_min_q <= mpwd_pkg::RST_SHORT_MIN;
			long_min_q  <= mpwd_pkg::RST_LONG_MIN;
			max_width_q <= mpwd_pkg::RST_MAX_WIDTH;
			pre_longs_q <= mpwd_pkg::RST_PRE_LONGS;
			pkt_bits_q  <= mpwd_pkg::RST_PKT_BITS;
		end else if (cfg_we) begin
			case (cfg_index)
				mpwd_pkg::REG_SHORT_MIN: short_min_q <= cfg_data;
				mpwd_pkg::REG_LONG_MIN:  long_min_q  <= cfg_data;
				mpwd_pkg::REG_MAX_WIDTH: max_width_q <= cfg_data;
				mpwd_pkg::REG_PRE_LONGS: pre_longs_q <= cfg_data[mpwd_pkg::COUNT_W-1:0];
				mpwd_pkg::REG_PKT_BITS:  pkt_bits_q  <= cfg_data[mpwd_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign pkt_cfg.pre_longs = pre_longs_q;
	assign pkt_cfg.pkt_bits  = pkt_bits_q;

	// Take a pulse whenever the queue has room
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// Classify against the width window
	assign in_window = (pulse_width >= short_min_q) && (pulse_width < max_width_q);
	always_comb begin
		q_item.width = pulse_width;
		if (!in_window)
			q_item.cls = mpwd_pkg::CLS_RANGE;
		else if (pulse_width >= long_min_q)
			q_item.cls = mpwd_pkg::CLS_LONG;
		else
			q_item.cls = mpwd_pkg::CLS_SHORT;
	end

endmodule
`default_nettype wire

FILE: src/mpwd_queue.sv
// Two-entry queue of classified pulses between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module mpwd_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire mpwd_pkg::item_t push_item,
	output logic                 full,
	input  wire logic            pop,
	output mpwd_pkg::item_t      pop_item,
	output logic                 not_empty
);

	mpwd_pkg::item_t entry_q [2];
	logic            wr_ptr_q, rd_ptr_q;
	logic [1:0]      count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_item  = entry_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: src/mpwd_back.sv
// Back end: preamble hunt, Manchester decoding, byte store and result output.
`timescale 1ns / 1ps
`default_nettype none
module mpwd_back #(
	parameter int MAX_BYTES = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire mpwd_pkg::pkt_cfg_t           pkt_cfg,
	input  wire logic                         q_valid,
	input  wire mpwd_pkg::item_t              q_item,
	output logic                              q_pop,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [1:0]                        status,
	output logic [mpwd_pkg::BYTE_W-1:0]       data_byte,
	output logic                              byte_last,
	output logic [mpwd_pkg::WIDTH_W-1:0]      short_width
);

	localparam int AW = $clog2(MAX_BYTES);
	localparam int XW = AW + 4;
	localparam logic B_RUN  = 1'b0;
	localparam logic B_EMIT = 1'b1;

	// Decoder state
	logic [1:0]                   phase_q, phase_d;
	logic [mpwd_pkg::COUNT_W-1:0] wbc_q, wbc_d, fpc_q, fpc_d;
	logic [mpwd_pkg::WIDTH_W-1:0] lsw_q, lsw_d;
	logic [mpwd_pkg::BYTE_W-1:0]  store_q [MAX_BYTES];
	logic                         bstate_q, bstate_d;
	logic [3:0]                   emit_cnt_q, emit_cnt_d, emit_end_q, emit_end_d;

	// Output register
	logic                         out_valid_q;
	logic [1:0]                   status_q;
	logic [mpwd_pkg::BYTE_W-1:0]  data_byte_q;
	logic                         byte_last_q;
	logic [mpwd_pkg::WIDTH_W-1:0] short_width_q;

	logic                         out_free;
	logic                         res_load;
	logic [1:0]                   res_status;
	logic [mpwd_pkg::BYTE_W-1:0]  res_byte;
	logic                         res_last;
	logic [mpwd_pkg::WIDTH_W-1:0] res_sw;

	logic                         st_we;
	logic [AW-1:0]                st_addr;
	logic [mpwd_pkg::BYTE_W-1:0]  st_rdata, st_wdata;

	logic                         tb, tb_flip, is_long;
	logic [mpwd_pkg::COUNT_W-1:0] fpc_tb, wbc_inc;
	logic [XW-1:0]                widx_x, nidx_x, emit_x;

	assign out_free = !out_valid_q || out_ready;
	assign q_pop    = (bstate_q == B_RUN) && q_valid && out_free;

	// Single read port on the byte store: emit index or current write slot
	assign widx_x   = {{AW{1'b0}}, wbc_q[7:4]};
	assign emit_x   = {{AW{1'b0}}, emit_cnt_q};
	assign st_addr  = (bstate_q == B_EMIT) ? emit_x[AW-1:0] : widx_x[AW-1:0];
	assign st_rdata = store_q[st_addr];

	// Next-state logic for one popped pulse or one emitted byte
	always_comb begin
		phase_d    = phase_q;
		wbc_d      = wbc_q;
		fpc_d      = fpc_q;
		lsw_d      = lsw_q;
		bstate_d   = bstate_q;
		emit_cnt_d = emit_cnt_q;
		emit_end_d = emit_end_q;
		res_load   = 1'b0;
		res_status = mpwd_pkg::ST_OK;
		res_byte   = '0;
		res_last   = 1'b0;
		res_sw     = '0;
		st_we      = 1'b0;
		st_wdata   = '0;
		tb         = 1'b0;
		tb_flip    = 1'b0;
		is_long    = (q_item.cls == mpwd_pkg::CLS_LONG);
		fpc_tb     = '0;
		wbc_inc    = '0;
		nidx_x     = '0;

		if (bstate_q == B_EMIT) begin
			// Burst out stored bytes, lowest entry first
			if (out_free) begin
				res_load   = 1'b1;
				res_status = mpwd_pkg::ST_BYTE;
				res_byte   = st_rdata;
				res_last   = (emit_cnt_q == emit_end_q);
				res_sw     = lsw_q;
				if (emit_cnt_q == emit_end_q)
					bstate_d = B_RUN;
				else
					emit_cnt_d = emit_cnt_q + 4'd1;
			end
		end else if (q_pop) begin
			res_load = 1'b1;
			if (q_item.cls == mpwd_pkg::CLS_RANGE) begin
				res_status = mpwd_pkg::ST_RANGE;
			end else begin
				case (phase_q)
					mpwd_pkg::PH_HUNT: begin
						if (is_long) begin
							if (fpc_q != 8'hFF)
								fpc_d = fpc_q + 8'd1;
						end else if (fpc_q >= pkt_cfg.pre_longs) begin
							fpc_d   = '0;
							phase_d = mpwd_pkg::PH_T0;
						end else begin
							phase_d    = mpwd_pkg::PH_HUNT;
							wbc_d      = '0;
							fpc_d      = '0;
							res_status = mpwd_pkg::ST_BROKEN;
						end
					end
					mpwd_pkg::PH_OK: begin
						if (!is_long) begin
							phase_d = mpwd_pkg::PH_T0;
						end else begin
							tb      = 1'b1;
							tb_flip = 1'b1;
						end
					end
					default: begin
						if (!is_long) begin
							lsw_d = q_item.width;
							tb    = 1'b1;
						end else begin
							phase_d    = mpwd_pkg::PH_HUNT;
							wbc_d      = '0;
							fpc_d      = '0;
							res_status = mpwd_pkg::ST_BROKEN;
						end
					end
				endcase

				// Record one wire bit
				if (tb) begin
					fpc_tb = fpc_q ^ {7'd0, tb_flip};
					fpc_d  = fpc_tb;
					if (!wbc_q[0] && (widx_x < XW'(MAX_BYTES))) begin
						st_we    = 1'b1;
						st_wdata = {(fpc_tb != '0), st_rdata[mpwd_pkg::BYTE_W-1:1]};
					end
					wbc_inc = wbc_q + 8'd1;
					wbc_d   = wbc_inc;
					nidx_x  = {{AW{1'b0}}, wbc_inc[7:4]};
					if (nidx_x >= XW'(MAX_BYTES)) begin
						phase_d    = mpwd_pkg::PH_HUNT;
						wbc_d      = '0;
						fpc_d      = '0;
						res_status = mpwd_pkg::ST_BROKEN;
					end else begin
						phase_d = mpwd_pkg::PH_OK;
						if (wbc_inc >= pkt_cfg.pkt_bits) begin
							// Packet complete: bytes follow instead of a status result
							res_load   = 1'b0;
							bstate_d   = B_EMIT;
							emit_cnt_d = '0;
							emit_end_d = wbc_inc[7:4];
							phase_d    = mpwd_pkg::PH_HUNT;
							wbc_d      = '0;
							fpc_d      = '0;
						end
					end
				end
			end
		end
	end

	// Control and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= mpwd_pkg::PH_HUNT;
			wbc_q      <= '0;
			fpc_q      <= '0;
			lsw_q      <= '0;
			bstate_q   <= B_RUN;
			emit_cnt_q <= '0;
			emit_end_q <= '0;
		end else begin
			phase_q    <= phase_d;
			wbc_q      <= wbc_d;
			fpc_q      <= fpc_d;
			lsw_q      <= lsw_d;
			bstate_q   <= bstate_d;
			emit_cnt_q <= emit_cnt_d;
			emit_end_q <= emit_end_d;
		end
	end

	// Byte store, zero after reset and kept across packets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_BYTES; i++)
				store_q[i] <= '0;
		end else if (st_we) begin
			store_q[st_addr] <= st_wdata;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q      <= res_status;
			data_byte_q   <= res_byte;
			byte_last_q   <= res_last;
			short_width_q <= res_sw;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign data_byte   = data_byte_q;
	assign byte_last   = byte_last_q;
	assign short_width = short_width_q;

endmodule
`default_nettype wire

FILE: src/manchester_pulse_width_decoder_core.sv
// Top level of the Manchester pulse-width decoder.
//
// Input channel (in_valid/in_ready, pulse_width): one measured pulse width
// per transfer. The front end classifies it against the width registers and
// drops it into a two-entry queue; in_ready is low only while that queue is full.
// Output channel (out_valid/out_ready): one result per transfer with status,
// data_byte, byte_last and short_width, held in an output register.
// Config port (cfg_we, cfg_index, cfg_data): single-cycle register writes,
// to be issued only while the decoder is idle.
// A transferred pulse is written into the queue, then popped and decoded by the
// back end, whose result is held in the output register that drives out_valid.
// Throughput: one pulse per cycle while the output is taken every cycle.
// At packet end the back end bursts the stored bytes out (up to 16); pulses
// queue up meanwhile and in_ready drops when the queue fills. An output stall
// holds the result and backs up the queue.
// Reset: registers return to defaults, counters clear, byte store reads zero.
`timescale 1ns / 1ps
`default_nettype none
module manchester_pulse_width_decoder_core #(
	parameter int MAX_BYTES = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [mpwd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mpwd_pkg::WIDTH_W-1:0]   cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [mpwd_pkg::WIDTH_W-1:0]   pulse_width,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [1:0]                          status,
	output logic [mpwd_pkg::BYTE_W-1:0]         data_byte,
	output logic                                byte_last,
	output logic [mpwd_pkg::WIDTH_W-1:0]        short_width
);

	logic               q_full, q_push, q_pop, q_valid;
	mpwd_pkg::item_t    push_item, pop_item;
	mpwd_pkg::pkt_cfg_t pkt_cfg;

	mpwd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pulse_width (pulse_width),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (push_item),
		.pkt_cfg     (pkt_cfg)
	);

	mpwd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.not_empty (q_valid)
	);

	mpwd_back #(
		.MAX_BYTES (MAX_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pkt_cfg     (pkt_cfg),
		.q_valid     (q_valid),
		.q_item      (pop_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.data_byte   (data_byte),
		.byte_last   (byte_last),
		.short_width (short_width)
	);

endmodule
`default_nettype wire

FILE: tb/tb_manchester_pulse_width_decoder_core.sv
// Self-checking testbench for the Manchester pulse-width decoder core.
`timescale 1ns / 1ps
module tb_manchester_pulse_width_decoder_core;
	import mpwd_pkg::*;

	localparam int NUM_BYTES     = 16;
	localparam int MAX_BURST     = 16;
	localparam int MAX_IDLE      = 5;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 20;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int RAND_PULSES   = 40;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int WIDTH_MAX     = (1 << WIDTH_W) - 1;
	localparam int CFG_IDX_TOP   = (1 << CFG_IDX_W) - 1;

	// One queued stimulus entry: a pulse width or a register write
	typedef struct {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] index;
		logic [WIDTH_W-1:0]   value;
	} feed_t;

	// One decoder output as the predictor sees it
	typedef struct packed {
		logic [1:0]         st;
		logic [BYTE_W-1:0]  data_b;
		logic               last_b;
		logic [WIDTH_W-1:0] sw;
	} dec_out_t;

	logic                 clk;
	logic                 arst_n      = 1'b0;
	logic                 cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [WIDTH_W-1:0]   cfg_data    = '0;
	logic                 in_valid    = 1'b0;
	logic [WIDTH_W-1:0]   pulse_width = '0;
	logic                 out_ready   = 1'b0;
	logic                 in_ready;
	logic                 out_valid;
	logic [1:0]           status;
	logic [BYTE_W-1:0]    data_byte;
	logic                 byte_last;
	logic [WIDTH_W-1:0]   short_width;

	manchester_pulse_width_decoder_core #(
		.MAX_BYTES(NUM_BYTES)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pulse_width(pulse_width),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.data_byte  (data_byte),
		.byte_last  (byte_last),
		.short_width(short_width)
	);

	// 50 MHz clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	feed_t    feed_q[$];
	dec_out_t decode_q[$];

	int mismatches    = 0;
	int pulses_sent   = 0;
	int results_seen  = 0;
	int packets_seen  = 0;
	int cfg_writes    = 0;
	int queued_pulses = 0;
	int cycles        = 0;

	// Predictor copy of the registers and decoder state
	logic [WIDTH_W-1:0] m_short_min  = RST_SHORT_MIN;
	logic [WIDTH_W-1:0] m_long_min   = RST_LONG_MIN;
	logic [WIDTH_W-1:0] m_max        = RST_MAX_WIDTH;
	logic [COUNT_W-1:0] m_pre        = RST_PRE_LONGS;
	logic [COUNT_W-1:0] m_pkt        = RST_PKT_BITS;
	logic [1:0]         m_phase      = PH_HUNT;
	logic [COUNT_W-1:0] m_bits       = '0;
	logic [COUNT_W-1:0] m_count      = '0;
	logic [BYTE_W-1:0]  m_store [NUM_BYTES] = '{default: '0};
	logic [WIDTH_W-1:0] m_last_short = '0;

	// Stimulus-side view of the registers, used to pick widths
	int g_short_min = int'(RST_SHORT_MIN);
	int g_long_min  = int'(RST_LONG_MIN);
	int g_max       = int'(RST_MAX_WIDTH);
	int g_pre       = int'(RST_PRE_LONGS);
	int g_pkt       = int'(RST_PKT_BITS);

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("MISMATCH %s: got %0h expected %0h (result %0d, t=%0t)",
			what, got, want, results_seen, $realtime);
	endtask

	task automatic queue_result(input logic [1:0] st, input logic [BYTE_W-1:0] b,
			input logic last, input logic [WIDTH_W-1:0] sw);
		dec_out_t r;
		r.st     = st;
		r.data_b = b;
		r.last_b = last;
		r.sw     = sw;
		decode_q.push_back(r);
	endtask

	task automatic clear_frame();
		m_phase = PH_HUNT;
		m_bits  = '0;
		m_count = '0;
	endtask

	// Record one wire bit; even bits shift into the byte store from the top
	task automatic record_bit(input logic flip);
		int idx;
		int n;
		int i;
		m_count = m_count ^ {{(COUNT_W-1){1'b0}}, flip};
		if (!m_bits[0]) begin
			idx = int'(m_bits >> 4);
			if (idx < NUM_BYTES)
				m_store[idx] = {m_count != 0, m_store[idx][BYTE_W-1:1]};
		end
		m_bits = m_bits + COUNT_W'(1);
		idx = int'(m_bits >> 4);
		if (idx >= NUM_BYTES) begin
			clear_frame();
			queue_result(ST_BROKEN, '0, 1'b0, '0);
			return;
		end
		m_phase = PH_OK;
		if (m_bits >= m_pkt) begin
			// packet end: burst out the stored bytes from entry 0
			n = idx + 1;
			if (n > MAX_BURST)
				n = MAX_BURST;
			for (i = 0; i < n; i++)
				queue_result(ST_BYTE, m_store[i], i == n - 1, m_last_short);
			clear_frame();
		end else begin
			queue_result(ST_OK, '0, 1'b0, '0);
		end
	endtask

	// Work out the results of one accepted pulse
	task automatic decode_pulse(input logic [WIDTH_W-1:0] w);
		logic is_long;
		if (!(w >= m_short_min && w < m_max)) begin
			queue_result(ST_RANGE, '0, 1'b0, '0);
			return;
		end
		is_long = (w >= m_long_min);
		case (m_phase)
			PH_HUNT: begin
				if (is_long) begin
					if (m_count != '1)
						m_count = m_count + COUNT_W'(1);
					queue_result(ST_OK, '0, 1'b0, '0);
				end else if (m_count >= m_pre) begin
					m_count = '0;
					m_phase = PH_T0;
					queue_result(ST_OK, '0, 1'b0, '0);
				end else begin
					clear_frame();
					queue_result(ST_BROKEN, '0, 1'b0, '0);
				end
			end
			PH_OK: begin
				if (!is_long) begin
					m_phase = PH_T0;
					queue_result(ST_OK, '0, 1'b0, '0);
				end else begin
					record_bit(1'b1);
				end
			end
			default: begin
				// first half of a pair seen: a short repeats the bit
				if (!is_long) begin
					m_last_short = w;
					record_bit(1'b0);
				end else begin
					clear_frame();
					queue_result(ST_BROKEN, '0, 1'b0, '0);
				end
			end
		endcase
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [WIDTH_W-1:0] val);
		case (idx)
			REG_SHORT_MIN: m_short_min = val;
			REG_LONG_MIN:  m_long_min  = val;
			REG_MAX_WIDTH: m_max       = val;
			REG_PRE_LONGS: m_pre       = val[COUNT_W-1:0];
			REG_PKT_BITS:  m_pkt       = val[COUNT_W-1:0];
			default: ;
		endcase
	endtask

	// Driver: presents queued pulses and issues register writes when idle
	int  gap_left     = 0;
	int  quiet_cycles = 0;
	bit  in_burst     = 1'b0;

	always @(posedge clk) begin : drive_proc
		logic                 nxt_valid;
		logic [WIDTH_W-1:0]   nxt_width;
		logic                 nxt_we;
		logic [CFG_IDX_W-1:0] nxt_idx;
		logic [WIDTH_W-1:0]   nxt_data;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_we   <= 1'b0;
			gap_left = 0;
			quiet_cycles = 0;
		end else begin
			nxt_valid = in_valid;
			nxt_width = pulse_width;
			nxt_we    = 1'b0;
			nxt_idx   = cfg_index;
			nxt_data  = cfg_data;
			// pulse transfer: predict, then draw the wait before the next one
			if (in_valid && in_ready) begin
				decode_pulse(pulse_width);
				pulses_sent++;
				nxt_valid = 1'b0;
				if ($urandom_range(0, 39) == 0)
					in_burst = !in_burst;
				gap_left = in_burst ? 0 : $urandom_range(0, MAX_IDLE);
			end
			if (decode_q.size() == 0 && !in_valid && !cfg_we)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			if (!nxt_valid && feed_q.size() != 0) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (!feed_q[0].is_cfg) begin
					nxt_valid = 1'b1;
					nxt_width = feed_q[0].value;
					void'(feed_q.pop_front());
				end else if (quiet_cycles >= SETTLE_CYCLES) begin
					// register write only once the decoder has gone quiet
					nxt_we   = 1'b1;
					nxt_idx  = feed_q[0].index;
					nxt_data = feed_q[0].value;
					write_register(nxt_idx, nxt_data);
					void'(feed_q.pop_front());
					quiet_cycles = 0;
					cfg_writes++;
				end
			end
			in_valid    <= nxt_valid;
			pulse_width <= nxt_width;
			cfg_we      <= nxt_we;
			cfg_index   <= nxt_idx;
			cfg_data    <= nxt_data;
		end
	end

	// Monitor: random output stalls, each transfer checked against the oldest prediction
	int stall_left = 0;
	bit out_burst  = 1'b0;

	always @(posedge clk) begin : sink_proc
		dec_out_t want;
		logic     nxt_ready;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			nxt_ready = out_ready;
			if (out_valid && out_ready) begin
				results_seen++;
				if (decode_q.size() == 0) begin
					report_mismatch("result with nothing pending", 32'(status), 32'd0);
				end else begin
					want = decode_q.pop_front();
					if (status !== want.st)
						report_mismatch("status", 32'(status), 32'(want.st));
					if (data_byte !== want.data_b)
						report_mismatch("data_byte", 32'(data_byte), 32'(want.data_b));
					if (byte_last !== want.last_b)
						report_mismatch("byte_last", 32'(byte_last), 32'(want.last_b));
					if (short_width !== want.sw)
						report_mismatch("short_width", 32'(short_width), 32'(want.sw));
					if (want.st == ST_BYTE && want.last_b)
						packets_seen++;
				end
				if ($urandom_range(0, 39) == 0)
					out_burst = !out_burst;
				stall_left = out_burst ? 0 : $urandom_range(0, MAX_IDLE);
				nxt_ready = (stall_left == 0);
			end else if (!out_ready) begin
				if (stall_left != 0)
					stall_left--;
				nxt_ready = (stall_left == 0);
			end
			out_ready <= nxt_ready;
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Stimulus helpers
	task automatic push_pulse(input logic [WIDTH_W-1:0] w);
		feed_t f;
		f.is_cfg = 1'b0;
		f.index  = '0;
		f.value  = w;
		feed_q.push_back(f);
		queued_pulses++;
	endtask

	task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [WIDTH_W-1:0] val);
		feed_t f;
		f.is_cfg = 1'b1;
		f.index  = idx;
		f.value  = val;
		feed_q.push_back(f);
		case (idx)
			REG_SHORT_MIN: g_short_min = int'(val);
			REG_LONG_MIN:  g_long_min  = int'(val);
			REG_MAX_WIDTH: g_max       = int'(val);
			REG_PRE_LONGS: g_pre       = int'(val[COUNT_W-1:0]);
			REG_PKT_BITS:  g_pkt       = int'(val[COUNT_W-1:0]);
			default: ;
		endcase
	endtask

	function automatic bit can_frame();
		int short_top;
		int long_lo;
		short_top = (g_long_min < g_max) ? g_long_min : g_max;
		long_lo   = (g_long_min > g_short_min) ? g_long_min : g_short_min;
		return (g_short_min < short_top) && (long_lo < g_max);
	endfunction

	function automatic int pick_short();
		int hi;
		hi = ((g_long_min < g_max) ? g_long_min : g_max) - 1;
		return $urandom_range(g_short_min, hi);
	endfunction

	function automatic int pick_long();
		int lo;
		lo = (g_long_min > g_short_min) ? g_long_min : g_short_min;
		return $urandom_range(lo, g_max - 1);
	endfunction

	// A width outside the window: below the short minimum or at/above the max
	function automatic int pick_reject();
		if (g_short_min != 0 && $urandom_range(0, 1) == 1)
			return $urandom_range(0, g_short_min - 1);
		return $urandom_range(g_max, WIDTH_MAX);
	endfunction

	// Preamble, sync short, then Manchester wire bits; stops early at cut_at
	task automatic send_frame(input int pre_n, input int nbits, input int long_pct,
			input int cut_at);
		int b;
		repeat (pre_n) push_pulse(WIDTH_W'(pick_long()));
		push_pulse(WIDTH_W'(pick_short()));
		for (b = 0; b < nbits && b != cut_at; b++) begin
			if ($urandom_range(0, 24) == 0)
				push_pulse(WIDTH_W'(pick_reject()));
			if (b == 0 || $urandom_range(1, 100) > long_pct) begin
				push_pulse(WIDTH_W'(pick_short()));
				if (b != 0)
					push_pulse(WIDTH_W'(pick_short()));
			end else begin
				push_pulse(WIDTH_W'(pick_long()));
			end
		end
	endtask

	initial begin
		int target;
		int kind;
		int nbits;
		int drain;
		int k;
		int w;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Defaults: window edges, short with no preamble, rejects at the top
		push_pulse(16'd0);
		push_pulse(16'd199);
		push_pulse(16'd200);
		push_pulse(16'd1199);
		push_pulse(16'd1200);
		push_pulse(16'hFFFF);
		push_pulse(16'd699);

		// Narrow window, short packet; writes past the register list are ignored
		push_cfg(REG_SHORT_MIN, 16'd10);
		push_cfg(REG_LONG_MIN, 16'd100);
		push_cfg(REG_MAX_WIDTH, 16'd200);
		push_cfg(REG_PRE_LONGS, 16'd2);
		push_cfg(REG_PKT_BITS, 16'd4);
		for (k = REG_PKT_BITS + 1; k <= CFG_IDX_TOP; k++)
			push_cfg(CFG_IDX_W'(k), 16'hFFFF);
		push_pulse(16'd9);
		push_pulse(16'd10);
		push_pulse(16'd199);
		push_pulse(16'd200);
		push_pulse(16'd150);
		push_pulse(16'd150);
		push_pulse(16'd50);
		push_pulse(16'd50);
		push_pulse(16'd50);
		push_pulse(16'd150);   // long right after one short breaks the pair
		push_pulse(16'd150);
		push_pulse(16'd150);
		push_pulse(16'd99);
		push_pulse(16'd99);
		push_pulse(16'd150);
		push_pulse(16'd150);
		push_pulse(16'd150);

		// Extremes: saturating preamble count over a full-scale window
		push_cfg(REG_SHORT_MIN, 16'd0);
		push_cfg(REG_LONG_MIN, 16'h8000);
		push_cfg(REG_MAX_WIDTH, 16'hFFFF);
		push_cfg(REG_PRE_LONGS, 16'd255);
		push_cfg(REG_PKT_BITS, 16'd8);
		send_frame(258, 8, 85, -1);
		push_pulse(16'hFFFF);
		push_pulse(16'd0);

		// Empty window, zero packet length
		push_cfg(REG_SHORT_MIN, 16'hFFFF);
		push_cfg(REG_LONG_MIN, 16'd0);
		push_cfg(REG_MAX_WIDTH, 16'd0);
		push_cfg(REG_PRE_LONGS, 16'd0);
		push_cfg(REG_PKT_BITS, 16'd0);
		repeat (3) push_pulse(WIDTH_W'($urandom_range(0, WIDTH_MAX)));

		// Random settings, mostly well-formed frames with noise and cut frames
		target = queued_pulses + RAND_PULSES;
		while (queued_pulses < target) begin
			if ($urandom_range(0, 4) == 0) begin
				push_cfg(REG_SHORT_MIN, WIDTH_W'($urandom_range(0, WIDTH_MAX)));
				push_cfg(REG_LONG_MIN, WIDTH_W'($urandom_range(0, WIDTH_MAX)));
				push_cfg(REG_MAX_WIDTH, WIDTH_W'($urandom_range(0, WIDTH_MAX)));
			end else begin
				w = $urandom_range(0, 1000);
				push_cfg(REG_SHORT_MIN, WIDTH_W'(w));
				w += $urandom_range(1, 3000);
				push_cfg(REG_LONG_MIN, WIDTH_W'(w));
				w += $urandom_range(1, 3000);
				push_cfg(REG_MAX_WIDTH, WIDTH_W'(w));
			end
			push_cfg(REG_PRE_LONGS, {8'($urandom_range(0, 255)), 8'($urandom_range(0, 5))});
			push_cfg(REG_PKT_BITS, {8'($urandom_range(0, 255)),
				8'(($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 48))});
			if ($urandom_range(0, 3) == 0)
				push_cfg(CFG_IDX_W'($urandom_range(REG_PKT_BITS + 1, CFG_IDX_TOP)),
					WIDTH_W'($urandom_range(0, WIDTH_MAX)));
			repeat ($urandom_range(1, 3)) begin
				kind = $urandom_range(0, 9);
				if (kind == 0 || !can_frame()) begin
					repeat ($urandom_range(1, 6))
						push_pulse(WIDTH_W'($urandom_range(0, WIDTH_MAX)));
				end else begin
					nbits = (g_pkt == 0) ? 1 : g_pkt;
					send_frame(g_pre + $urandom_range(0, 2), nbits, $urandom_range(20, 80),
						(kind == 1) ? $urandom_range(0, nbits - 1) : -1);
				end
			end
		end

		// Drain
		while (feed_q.size() != 0 || in_valid)
			@(posedge clk);
		drain = 0;
		while (decode_q.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (decode_q.size() != 0)
			report_mismatch("results never delivered", 32'd0, decode_q.size());

		$display("tb: %0d pulses sent across %0d register writes, %0d results checked",
			pulses_sent, cfg_writes, results_seen);
		$display("tb: %0d packets decoded, %0d mismatches", packets_seen, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: sim.f
src/mpwd_pkg.sv
src/mpwd_front.sv
src/mpwd_queue.sv
src/mpwd_back.sv
src/manchester_pulse_width_decoder_core.sv
tb/tb_manchester_pulse_width_decoder_core.sv
